/* rtl/i2cms_pkg.sv */
// Shared word types and command codes for the I2C master bit sequencer.
`default_nettype none

package i2cms_pkg;

    localparam logic [2:0] FUNC_START = 3'd0;
    localparam logic [2:0] FUNC_STOP  = 3'd1;
    localparam logic [2:0] FUNC_SEND  = 3'd2;
    localparam logic [2:0] FUNC_RECV  = 3'd3;
    localparam logic [2:0] FUNC_SACK  = 3'd4;
    localparam logic [2:0] FUNC_RACK  = 3'd5;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_in;
    } out_word_t;

endpackage

`default_nettype wire

/* rtl/i2cms_seq.sv */
// Line-action sequencer: command state, step counters and one tick of line update.
`default_nettype none

module i2cms_seq (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  fire,
    input  i2cms_pkg::in_word_t  item,
    output i2cms_pkg::out_word_t result
);
    import i2cms_pkg::*;

    typedef enum logic [2:0] {
        K_START = 3'd0,
        K_STOP  = 3'd1,
        K_SEND  = 3'd2,
        K_RECV  = 3'd3,
        K_SACK  = 3'd4,
        K_RACK  = 3'd5,
        K_IDLE  = 3'd7
    } kind_t;

    kind_t      kind_reg, kind_next;
    logic [4:0] step_reg, step_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] shift_reg, shift_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic [7:0] rcv_reg, rcv_next;
    logic       rack_reg, rack_next;
    logic       pend_reg, pend_next;
    logic       done;

    kind_t      kind;
    logic [4:0] step;
    logic [1:0] phase;
    logic [4:0] last_step;

    always_comb
    begin
        kind       = kind_reg;
        step       = step_reg;
        phase      = phase_reg;
        shift_next = shift_reg;
        pend_next  = pend_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rcv_next   = rcv_reg;
        rack_next  = rack_reg;
        kind_next  = kind_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        done       = 1'b0;
        last_step  = 5'd0;

        if (fire)
        begin
            // Take a new command only when idle; undefined codes are dropped.
            if (kind_reg == K_IDLE && item.cmd_valid &&
                item.func inside {[FUNC_START:FUNC_RACK]})
            begin
                kind  = kind_t'(item.func);
                step  = 5'd0;
                phase = 2'd0;
                if (item.func == FUNC_SEND)
                    shift_next = item.tx_byte;
                else if (item.func == FUNC_RECV)
                    shift_next = 8'd0;
                if (item.func == FUNC_SACK)
                    pend_next = item.ack_out;
            end

            kind_next  = kind;
            step_next  = step;
            phase_next = phase;

            case (kind)
                K_START:
                begin
                    last_step = 5'd3;
                    case (step[1:0])
                        2'd0:    sda_next = 1'b1;
                        2'd1:    scl_next = 1'b1;
                        2'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                K_STOP:
                begin
                    last_step = 5'd2;
                    case (step[1:0])
                        2'd0:    sda_next = 1'b0;
                        2'd1:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                K_SEND:
                begin
                    // Drive the MSB, raise SCL, drop SCL and move to the next bit.
                    last_step = 5'd23;
                    case (phase)
                        2'd0: sda_next = shift_next[7];
                        2'd1: scl_next = 1'b1;
                        default:
                        begin
                            scl_next   = 1'b0;
                            shift_next = {shift_reg[6:0], 1'b0};
                        end
                    endcase
                    phase_next = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
                end
                K_RECV:
                begin
                    last_step = 5'd24;
                    if (step == 5'd0)
                    begin
                        sda_next = 1'b1;
                    end
                    else
                    begin
                        case (phase)
                            2'd0:    scl_next   = 1'b1;
                            2'd1:    shift_next = {shift_next[6:0], item.sda_in};
                            default: scl_next   = 1'b0;
                        endcase
                        phase_next = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
                    end
                end
                K_SACK:
                begin
                    last_step = 5'd2;
                    case (step[1:0])
                        2'd0:    sda_next = pend_next;
                        2'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end
                K_RACK:
                begin
                    last_step = 5'd3;
                    case (step[1:0])
                        2'd0:    sda_next  = 1'b1;
                        2'd1:    scl_next  = 1'b1;
                        2'd2:    rack_next = item.sda_in;
                        default: scl_next  = 1'b0;
                    endcase
                end
                default:
                begin
                    last_step = 5'd0;
                end
            endcase

            if (kind != K_IDLE)
            begin
                if (step == last_step)
                begin
                    done       = 1'b1;
                    kind_next  = K_IDLE;
                    step_next  = 5'd0;
                    phase_next = 2'd0;
                    if (kind == K_RECV)
                        rcv_next = shift_next;
                end
                else
                begin
                    step_next = step + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= K_IDLE;
            step_reg  <= 5'd0;
            phase_reg <= 2'd0;
            shift_reg <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            rcv_reg   <= 8'd0;
            rack_reg  <= 1'b1;
            pend_reg  <= 1'b0;
        end
        else
        begin
            kind_reg  <= kind_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            rcv_reg   <= rcv_next;
            rack_reg  <= rack_next;
            pend_reg  <= pend_next;
        end
    end

    assign result.scl_level = scl_next;
    assign result.sda_level = sda_next;
    assign result.busy_res  = (kind_next != K_IDLE);
    assign result.done_res  = done;
    assign result.rx_byte   = rcv_next;
    assign result.ack_in    = rack_next;

endmodule

`default_nettype wire

/* rtl/i2c_master_bit_sequencer.sv */
// Top level of the I2C master bit sequencer: input word register, sequencer, result register.
// Usage:
//   Each word on the item channel is one line-timing tick. It carries the sampled
//   SDA level and, when the sequencer is idle, an optional command (start, stop,
//   send byte, receive byte, send ack, read ack). Every tick gives exactly one
//   word on the result channel: SCL and SDA drive, busy, done, the last received
//   byte and the last read ack.
//   Both channels use valid and stall; a word moves on an edge with valid high and
//   stall low.
//   A tick word is loaded into the input register when it is accepted, and passes
//   through the sequencer into the result register when it advances. Throughput:
//   one tick per cycle while the result side does not stall, set by the single pass
//   of counter and shift logic between the two registers.
//   Reset: both lines released high, sequencer idle, received byte zero, read ack
//   one, both registers empty.
//   Stall on the result side: the result word holds; the input register keeps
//   one more tick and then raises stall on the item side.
`default_nettype none

module i2c_master_bit_sequencer (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_stall,
    input  i2cms_pkg::in_word_t  item,
    output logic                 result_valid,
    input  wire                  result_stall,
    output i2cms_pkg::out_word_t result
);
    import i2cms_pkg::*;

    in_word_t  in_reg;
    logic      in_valid_reg;
    out_word_t out_reg;
    logic      out_valid_reg;
    out_word_t step_word;
    logic      advance;

    // Advance a tick whenever the result register is empty or being drained.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    // Stall only when a tick waits and cannot advance.
    assign item_stall = in_valid_reg && !advance;

    i2cms_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_reg),
        .result (step_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Hold the input word until it advances; take a new one when free.
            if (item_valid && !item_stall)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_reg <= item;
        if (advance)
            out_reg <= step_word;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

/* rtl/i2cms_checker.sv */
// Port-level assertion checker for the I2C master bit sequencer, with its bind.
`default_nettype none

module i2cms_checker (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    input  wire                  item_stall,
    input  i2cms_pkg::in_word_t  item,
    input  wire                  result_valid,
    input  wire                  result_stall,
    input  i2cms_pkg::out_word_t result
);
    import i2cms_pkg::*;

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed under stall");

    // A finished command never reports busy on the same tick.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.done_res |-> !result.busy_res)
        else $error("done and busy together");

    // With the result side empty there is nothing to block the input.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled while result register empty");

    // Received byte only changes on a completing tick.
    a_rx_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && $past(result_valid) && !result.done_res
            |-> result.rx_byte == $past(result.rx_byte))
        else $error("received byte changed without done");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
